// File: design/llls_pkg.sv
package llls_pkg;

    localparam int TASK_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CPU_OUT_W = 4;
    localparam int LOAD_OUT_W = 40;
    localparam int OUT_DATA_W = 128;

    localparam logic [CFG_W-1:0] CPU_COUNT_RESET = 5'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_DONE
    } sched_state_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic wr_en;
    } cell_ctrl_t;

endpackage

// File: design/llls_cell.sv
module llls_cell #(
    parameter int LOAD_BITS = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  llls_pkg::cell_ctrl_t  ctrl,
    input  logic                  wr_sel,
    input  logic [LOAD_BITS-1:0]  wr_data,
    input  logic [LOAD_BITS-1:0]  shift_in,
    output logic [LOAD_BITS-1:0]  load_out
);
    import llls_pkg::*;

    logic [LOAD_BITS-1:0] load_reg;
    logic [LOAD_BITS-1:0] load_next;

    always_comb begin
        load_next = load_reg;
        if (ctrl.clear) begin
            load_next = '0;
        end else if (ctrl.wr_en && wr_sel) begin
            load_next = wr_data;
        end else if (ctrl.shift) begin
            load_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
        end else begin
            load_reg <= load_next;
        end
    end

    assign load_out = load_reg;

endmodule

// File: design/llls_ctrl.sv
module llls_ctrl #(
    parameter int MAX_CPUS  = 16,
    parameter int LOAD_BITS = 40,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [llls_pkg::TASK_W-1:0]     in_length,
    input  logic                            in_first,
    input  logic [CNT_W-1:0]                cpu_n,
    input  logic [LOAD_BITS-1:0]            head_load,
    output llls_pkg::cell_ctrl_t            cell_ctrl,
    output logic [IDX_W-1:0]                wr_idx,
    output logic [LOAD_BITS-1:0]            wr_data,
    input  logic                            out_free,
    output logic                            res_valid,
    output logic [IDX_W-1:0]                res_cpu,
    output logic [LOAD_BITS-1:0]            res_load,
    output logic [LOAD_BITS-1:0]            res_max,
    output logic [LOAD_BITS-1:0]            res_total
);
    import llls_pkg::*;

    localparam int SUM_W = ((LOAD_BITS > TASK_W) ? LOAD_BITS : TASK_W) + 1;
    localparam logic [SUM_W-1:0] LOAD_MAX_W = SUM_W'({LOAD_BITS{1'b1}});
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CPUS - 1);

    sched_state_t state_reg, state_next;

    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [TASK_W-1:0]    len_reg;
    logic [LOAD_BITS-1:0] min_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [LOAD_BITS-1:0] max_reg;
    logic [LOAD_BITS-1:0] sum_reg;
    logic [LOAD_BITS-1:0] new_load_reg;
    logic [LOAD_BITS-1:0] total_reg;

    logic                 accept;
    logic                 active;
    logic                 last_act;
    logic                 take;
    logic [SUM_W-1:0]     scan_sum;
    logic [LOAD_BITS-1:0] scan_sum_sat;
    logic [SUM_W-1:0]     add_load;
    logic [SUM_W-1:0]     add_total;
    logic [LOAD_BITS-1:0] makespan;

    assign accept   = in_valid && in_ready;
    assign active   = CNT_W'(idx_reg) < n_reg;
    assign last_act = CNT_W'(idx_reg) == (n_reg - CNT_W'(1));
    assign take     = (idx_reg == '0) || (head_load < min_reg)
                      || (last_act && (head_load <= min_reg));

    assign scan_sum     = SUM_W'(sum_reg) + SUM_W'(head_load);
    assign scan_sum_sat = (scan_sum > LOAD_MAX_W) ? LOAD_BITS'(LOAD_MAX_W)
                                                  : LOAD_BITS'(scan_sum);
    assign add_load  = SUM_W'(min_reg) + SUM_W'(len_reg);
    assign add_total = SUM_W'(sum_reg) + SUM_W'(len_reg);
    assign makespan  = (new_load_reg > max_reg) ? new_load_reg : max_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready        = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.wr_en = 1'b0;
        res_valid       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready        = aresetn;
                cell_ctrl.clear = accept && in_first;
            end
            ST_SCAN: begin
                cell_ctrl.shift = 1'b1;
            end
            ST_ADD: begin
            end
            ST_DONE: begin
                cell_ctrl.wr_en = out_free;
                res_valid       = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end else begin
                idx_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    len_reg <= in_length;
                    n_reg   <= cpu_n;
                end
            end
            ST_SCAN: begin
                if (active) begin
                    if (take) begin
                        min_reg  <= head_load;
                        pick_reg <= idx_reg;
                    end
                    if (idx_reg == '0) begin
                        max_reg <= head_load;
                        sum_reg <= head_load;
                    end else begin
                        if (head_load > max_reg) begin
                            max_reg <= head_load;
                        end
                        sum_reg <= scan_sum_sat;
                    end
                end
            end
            ST_ADD: begin
                new_load_reg <= (add_load > LOAD_MAX_W) ? LOAD_BITS'(LOAD_MAX_W)
                                                        : LOAD_BITS'(add_load);
                total_reg    <= (add_total > LOAD_MAX_W) ? LOAD_BITS'(LOAD_MAX_W)
                                                         : LOAD_BITS'(add_total);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign wr_idx    = pick_reg;
    assign wr_data   = new_load_reg;
    assign res_cpu   = pick_reg;
    assign res_load  = new_load_reg;
    assign res_max   = makespan;
    assign res_total = total_reg;

endmodule

// File: design/least_loaded_list_scheduler_unit.sv
// Greedy list scheduler: each input item is one task length, placed on the least-loaded
// of the first cpu_count processors (lowest index wins a tie, unless nothing is strictly
// below the last processor in use, which then wins). Loads saturate at 2^LOAD_BITS - 1,
// and tuser set on an input item clears all loads before the task is placed. The loads
// live in a ring of MAX_CPUS cells that rotates once per task past a single compare and
// accumulate unit. An item passes an accept state, the ring rotation, a saturating add and
// a write-back before the next item is accepted. The result waits in an output register,
// so the next item is taken while it is unread, but its write-back waits until that
// result is read. cpu_count must be written through the cfg channel only while idle;
// the block does not enforce it. Zero acts as one processor and values above MAX_CPUS act as MAX_CPUS.
module least_loaded_list_scheduler_unit #(
    parameter int MAX_CPUS  = 16,
    parameter int LOAD_BITS = 40
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [llls_pkg::CFG_W-1:0]           cfg_data,    // cpu_count
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [llls_pkg::TASK_W-1:0]          s_tdata,     // job_ticks
    input  logic                                 s_tuser,     // first_task
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // chosen_cpu [3:0], chosen_load [43:4], makespan [83:44], total_load [123:84], zero pad
    output logic [llls_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import llls_pkg::*;

    localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W = $clog2(MAX_CPUS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]     cpu_count_reg;
    logic [CNT_W-1:0]     cpu_n;
    logic [CMP_W-1:0]     cfg_wide;

    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                 out_free;

    cell_ctrl_t           cell_ctrl;
    logic [IDX_W-1:0]     wr_idx;
    logic [LOAD_BITS-1:0] wr_data;
    logic [LOAD_BITS-1:0] loads [MAX_CPUS];

    logic                 res_valid;
    logic [IDX_W-1:0]     res_cpu;
    logic [LOAD_BITS-1:0] res_load;
    logic [LOAD_BITS-1:0] res_max;
    logic [LOAD_BITS-1:0] res_total;
    logic [63:0]          load_w, max_w, total_w;
    logic [63:0]          cpu_w;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_count_reg <= CPU_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cpu_count_reg <= cfg_data;
        end
    end

    assign cfg_wide = CMP_W'(cpu_count_reg);

    always_comb begin
        if (cfg_wide == '0) begin
            cpu_n = CNT_W'(1);
        end else if (cfg_wide > CMP_W'(MAX_CPUS)) begin
            cpu_n = CNT_W'(MAX_CPUS);
        end else begin
            cpu_n = CNT_W'(cfg_wide);
        end
    end

    for (genvar g = 0; g < MAX_CPUS; g++) begin : g_ring
        llls_cell #(
            .LOAD_BITS (LOAD_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .wr_sel   (wr_idx == IDX_W'(g)),
            .wr_data  (wr_data),
            .shift_in (loads[(g + 1) % MAX_CPUS]),
            .load_out (loads[g])
        );
    end

    llls_ctrl #(
        .MAX_CPUS  (MAX_CPUS),
        .LOAD_BITS (LOAD_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_length (s_tdata),
        .in_first  (s_tuser),
        .cpu_n     (cpu_n),
        .head_load (loads[0]),
        .cell_ctrl (cell_ctrl),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_cpu   (res_cpu),
        .res_load  (res_load),
        .res_max   (res_max),
        .res_total (res_total)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    assign cpu_w   = 64'(res_cpu);
    assign load_w  = 64'(res_load);
    assign max_w   = 64'(res_max);
    assign total_w = 64'(res_total);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {4'b0000,
                            total_w[LOAD_OUT_W-1:0],
                            max_w[LOAD_OUT_W-1:0],
                            load_w[LOAD_OUT_W-1:0],
                            cpu_w[CPU_OUT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/llls_checker.sv
module llls_checker #(
    parameter int LOAD_BITS = 40
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    property p_hold_result;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty
    a_hold_result: assert property (p_hold_result)
        else $error("Result item changed while stalled.");

    property p_one_at_a_time;
        @(posedge aclk) disable iff (!aresetn)
            s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_one_at_a_time: assert property (p_one_at_a_time)
        else $error("Input taken again right after an accepted item.");

    property p_reset_clears;
        @(posedge aclk) !aresetn |=> !m_tvalid;
    endproperty
    a_reset_clears: assert property (p_reset_clears)
        else $error("Result valid after reset.");

    property p_load_within_span;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid |-> (LOAD_BITS > 40) || (m_tdata[43:4] <= m_tdata[83:44]);
    endproperty
    a_load_within_span: assert property (p_load_within_span)
        else $error("Chosen load exceeds makespan.");

    property p_span_within_total;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid |-> (LOAD_BITS > 40) || (m_tdata[83:44] <= m_tdata[123:84]);
    endproperty
    a_span_within_total: assert property (p_span_within_total)
        else $error("Makespan exceeds total load.");

endmodule

bind least_loaded_list_scheduler_unit llls_checker #(
    .LOAD_BITS (LOAD_BITS)
) u_llls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_least_loaded_list_scheduler_unit.sv
`timescale 1ns / 100ps

module tb_least_loaded_list_scheduler_unit;

    import llls_pkg::*;

    localparam int MAX_CPUS   = 16;
    localparam int LOAD_BITS  = 40;
    localparam int HOLD_LEN   = 400;
    localparam int ITEM_GOAL  = 1300;

    typedef logic [LOAD_BITS-1:0] load_t;

    typedef struct packed {
        logic [CPU_OUT_W-1:0] cpu;
        load_t                load;
        load_t                span;
        load_t                total;
    } placement_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TASK_W-1:0]      s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    load_t                  cpu_load_model [MAX_CPUS];
    logic [CFG_W-1:0]       cpu_count_model;
    placement_t             expected_placements [$];
    int                     mismatch_count = 0;
    int                     items_sent     = 0;
    int                     tx_run_left    = 0;
    int                     rx_run_left    = 0;
    bit                     long_hold_req  = 1'b0;

    least_loaded_list_scheduler_unit #(
        .MAX_CPUS  (MAX_CPUS),
        .LOAD_BITS (LOAD_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic load_t sat_load_add(input load_t a, input load_t b);
        logic [LOAD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];
    endfunction

    function automatic placement_t place_task(input logic [TASK_W-1:0] len, input logic first);
        placement_t r;
        int         n;
        int         pick;
        n = int'(cpu_count_model);
        if (n == 0) n = 1;
        if (n > MAX_CPUS) n = MAX_CPUS;
        if (first) begin
            for (int i = 0; i < MAX_CPUS; i++) cpu_load_model[i] = '0;
        end
        pick = n - 1;
        for (int i = 0; i < n; i++) begin
            if (cpu_load_model[i] < cpu_load_model[pick]) pick = i;
        end
        cpu_load_model[pick] = sat_load_add(cpu_load_model[pick], load_t'(len));
        r.cpu   = CPU_OUT_W'(pick);
        r.load  = cpu_load_model[pick];
        r.span  = '0;
        r.total = '0;
        for (int i = 0; i < n; i++) begin
            if (cpu_load_model[i] > r.span) r.span = cpu_load_model[i];
            r.total = sat_load_add(r.total, cpu_load_model[i]);
        end
        return r;
    endfunction

    function automatic logic [TASK_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 15);
            4, 5: return $urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input load_t got, input load_t want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        end
    endtask

    task automatic offer_task(input logic [TASK_W-1:0] len, input logic first);
        int gap;
        if (tx_run_left > 0) begin
            tx_run_left--;
            gap = 0;
        end else if ($urandom_range(0, 31) == 0) begin
            tx_run_left = $urandom_range(10, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_placements.push_back(place_task(len, first));
        items_sent++;
    endtask

    task automatic await_placements();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_placements.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cpu_count(input logic [CFG_W-1:0] count);
        await_placements();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cpu_count_model = count;
    endtask

    task automatic test_reset_default_count();
        offer_task(32'd0, 1'b0);
        offer_task(32'd0, 1'b0);
        offer_task(32'd1, 1'b0);
        offer_task(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_tie_rule();
        offer_task(32'd7, 1'b1);
        offer_task(32'h5555_5555, 1'b0);
        offer_task(32'hAAAA_AAAA, 1'b0);
        offer_task(32'd3, 1'b0);
        offer_task(32'd4, 1'b0);
    endtask

    task automatic test_count_extremes();
        write_cpu_count(5'd0);
        offer_task(32'd9, 1'b1);
        offer_task(32'hFFFF_FFFF, 1'b0);
        write_cpu_count(5'd1);
        offer_task(32'd1, 1'b0);
        write_cpu_count(5'd16);
        offer_task(32'd0, 1'b1);
        offer_task(32'd5, 1'b0);
        offer_task(32'd5, 1'b0);
        write_cpu_count(5'd17);
        offer_task(32'd2, 1'b0);
        write_cpu_count(5'd31);
        offer_task(32'd0, 1'b0);
    endtask

    task automatic test_idle_processors_kept();
        write_cpu_count(5'd16);
        offer_task(32'd40, 1'b1);
        offer_task(32'd30, 1'b0);
        offer_task(32'd20, 1'b0);
        write_cpu_count(5'd2);
        offer_task(32'd100, 1'b0);
        offer_task(32'd100, 1'b0);
        write_cpu_count(5'd16);
        offer_task(32'd1, 1'b0);
        offer_task(32'd1, 1'b0);
        write_cpu_count(5'd2);
        offer_task(32'd50, 1'b1);
        write_cpu_count(5'd16);
        offer_task(32'd0, 1'b0);
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        tx_run_left   = 24;
        repeat (24) offer_task(random_length(), 1'b0);
        await_placements();
    endtask

    task automatic test_load_saturation();
        // Two processors overflow the total first; one processor then overflows its own load.
        write_cpu_count(5'd2);
        offer_task($urandom_range(32'hF000_0000, 32'hFFFF_FFFF), 1'b1);
        repeat (299) offer_task($urandom_range(32'hF000_0000, 32'hFFFF_FFFF), 1'b0);
        write_cpu_count(5'd1);
        repeat (150) offer_task($urandom_range(32'hF000_0000, 32'hFFFF_FFFF), 1'b0);
        write_cpu_count(5'd3);
        repeat (20) offer_task($urandom_range(32'hF000_0000, 32'hFFFF_FFFF), 1'b0);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] count;
        int               phase_len;
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 7))
                0: count = 5'd0;
                1: count = 5'd1;
                2: count = 5'd16;
                3: count = 5'd31;
                default: count = CFG_W'($urandom_range(0, 31));
            endcase
            write_cpu_count(count);
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) offer_task(random_length(), $urandom_range(0, 19) == 0);
        end
    endtask

    always @(posedge aclk) begin : check_results
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_placements.size() == 0) begin
                flag_mismatch("unexpected item", m_tdata[43:4], '0);
            end else begin
                want = expected_placements.pop_front();
                if (m_tdata[3:0] !== want.cpu) begin
                    flag_mismatch("chosen_cpu", load_t'(m_tdata[3:0]), load_t'(want.cpu));
                end
                if (m_tdata[43:4] !== want.load) begin
                    flag_mismatch("chosen_load", m_tdata[43:4], want.load);
                end
                if (m_tdata[83:44] !== want.span) begin
                    flag_mismatch("makespan", m_tdata[83:44], want.span);
                end
                if (m_tdata[123:84] !== want.total) begin
                    flag_mismatch("total_load", m_tdata[123:84], want.total);
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            if (rx_run_left > 0) begin
                rx_run_left--;
                stall = 0;
            end else if ($urandom_range(0, 31) == 0) begin
                rx_run_left = $urandom_range(10, 30);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready) && !long_hold_req) @(posedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_least_loaded_list_scheduler_unit: done, errors");
        $finish;
    end

    initial begin
        cpu_count_model = CPU_COUNT_RESET;
        for (int i = 0; i < MAX_CPUS; i++) cpu_load_model[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_default_count();
        test_tie_rule();
        test_count_extremes();
        test_idle_processors_kept();
        test_output_backpressure();
        test_load_saturation();
        test_random_phases();

        await_placements();
        repeat (40) @(posedge aclk);
        if (expected_placements.size() != 0) begin
            flag_mismatch("missing items", load_t'(expected_placements.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("tb_least_loaded_list_scheduler_unit: done, clean");
        end else begin
            $display("tb_least_loaded_list_scheduler_unit: done, errors");
        end
        $finish;
    end

endmodule
